>>> rtl/core/dws_pkg.sv
// Package for the double-ended queue with search.
// Holds the field widths, the operation and status codes and the
// controller-to-datapath command and status structs. No dependencies.
package dws_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_LIST       = 3'd5
  } dws_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } dws_status_t;

  // Source of the value carried by a result.
  typedef enum logic [1:0] {
    VSEL_ZERO,
    VSEL_RDATA,
    VSEL_KEY
  } dws_vsel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REPLY,
    S_POP,
    S_SEARCH,
    S_LIST
  } dws_state_t;

  typedef struct packed {
    logic        capture;
    logic        push_front;
    logic        push_back;
    logic        pop_front;
    logic        pop_back;
    logic        scan_start;
    logic        scan_next;
    logic        emit;
    dws_vsel_t   emit_sel;
    dws_status_t emit_status;
    logic        emit_last;
  } dws_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic scan_last;
    logic out_free;
  } dws_stat_t;

endpackage

>>> rtl/core/dws_in_if.sv
// Input channel of the double-ended queue: valid/ready with opcode and value.
// Depends on dws_pkg for the field widths.
interface dws_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [dws_pkg::OPCODE_W-1:0]  opcode;
  logic signed [dws_pkg::VALUE_W-1:0]   value_in;

  modport source (output valid, output opcode, output value_in, input ready);
  modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

>>> rtl/core/dws_out_if.sv
// Result channel of the double-ended queue: valid/ready with value, status,
// occupancy and end-of-run mark. Depends on dws_pkg for the field widths.
interface dws_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dws_pkg::VALUE_W-1:0]   value_out;
  logic        [dws_pkg::STATUS_W-1:0]  status;
  logic        [dws_pkg::OCC_W-1:0]     occupancy;
  logic                                 last_of_run;

  modport source (output valid, output value_out, output status, output occupancy,
                  output last_of_run, input ready);
  modport sink   (input valid, input value_out, input status, input occupancy,
                  input last_of_run, output ready);
endinterface

>>> rtl/core/dws_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/dws_ctrl.sv
// Controller of the double-ended queue: decodes each transfer and sequences
// pushes, pops and scans. Depends on dws_pkg; drives the datapath by dws_cmd_t.
module dws_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [dws_pkg::OPCODE_W-1:0]    in_opcode,
  output logic                            in_ready,
  input  dws_pkg::dws_stat_t              stat,
  output dws_pkg::dws_cmd_t               cmd
);

  dws_pkg::dws_state_t  state_r, state_nxt;
  dws_pkg::dws_status_t reply_r, reply_nxt;
  dws_pkg::dws_op_t     op;

  assign op = dws_pkg::dws_op_t'(in_opcode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dws_pkg::S_IDLE;
      reply_r <= dws_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      reply_r <= reply_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    reply_nxt = reply_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.emit_sel    = dws_pkg::VSEL_ZERO;
    cmd.emit_status = dws_pkg::ST_OK;
    unique case (state_r)
      dws_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (op)
            dws_pkg::OP_PUSH_FRONT: begin
              state_nxt      = dws_pkg::S_REPLY;
              reply_nxt      = stat.full ? dws_pkg::ST_FULL : dws_pkg::ST_OK;
              cmd.push_front = !stat.full;
            end
            dws_pkg::OP_PUSH_BACK: begin
              state_nxt     = dws_pkg::S_REPLY;
              reply_nxt     = stat.full ? dws_pkg::ST_FULL : dws_pkg::ST_OK;
              cmd.push_back = !stat.full;
            end
            dws_pkg::OP_POP_FRONT: begin
              if (stat.empty) begin
                state_nxt = dws_pkg::S_REPLY;
                reply_nxt = dws_pkg::ST_EMPTY;
              end else begin
                state_nxt     = dws_pkg::S_POP;
                cmd.pop_front = 1'b1;
              end
            end
            dws_pkg::OP_POP_BACK: begin
              if (stat.empty) begin
                state_nxt = dws_pkg::S_REPLY;
                reply_nxt = dws_pkg::ST_EMPTY;
              end else begin
                state_nxt    = dws_pkg::S_POP;
                cmd.pop_back = 1'b1;
              end
            end
            dws_pkg::OP_SEARCH: begin
              cmd.capture = 1'b1;
              if (stat.empty) begin
                state_nxt = dws_pkg::S_REPLY;
                reply_nxt = dws_pkg::ST_NOTFOUND;
              end else begin
                state_nxt      = dws_pkg::S_SEARCH;
                cmd.scan_start = 1'b1;
              end
            end
            dws_pkg::OP_LIST: begin
              if (stat.empty) begin
                state_nxt = dws_pkg::S_REPLY;
                reply_nxt = dws_pkg::ST_EMPTY;
              end else begin
                state_nxt      = dws_pkg::S_LIST;
                cmd.scan_start = 1'b1;
              end
            end
            default: begin
              // Unused opcodes are dropped without a result.
              state_nxt = dws_pkg::S_IDLE;
            end
          endcase
        end
      end
      dws_pkg::S_REPLY: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = dws_pkg::VSEL_ZERO;
          cmd.emit_status = reply_r;
          cmd.emit_last   = 1'b1;
          state_nxt       = dws_pkg::S_IDLE;
        end
      end
      dws_pkg::S_POP: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = dws_pkg::VSEL_RDATA;
          cmd.emit_last = 1'b1;
          state_nxt     = dws_pkg::S_IDLE;
        end
      end
      dws_pkg::S_SEARCH: begin
        priority if (stat.match) begin
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = dws_pkg::VSEL_KEY;
            cmd.emit_last = 1'b1;
            state_nxt     = dws_pkg::S_IDLE;
          end
        end else if (stat.scan_last) begin
          if (stat.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = dws_pkg::ST_NOTFOUND;
            cmd.emit_last   = 1'b1;
            state_nxt       = dws_pkg::S_IDLE;
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      dws_pkg::S_LIST: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = dws_pkg::VSEL_RDATA;
          cmd.emit_last = stat.scan_last;
          if (stat.scan_last) begin
            state_nxt = dws_pkg::S_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = dws_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/dws_dpath.sv
// Datapath of the double-ended queue: ring pointers, entry count, scan counter,
// entry RAM and output register. Depends on dws_pkg and dws_ram.
module dws_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dws_pkg::dws_cmd_t                   cmd,
  output dws_pkg::dws_stat_t                  stat,
  input  logic signed [dws_pkg::VALUE_W-1:0]  in_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [dws_pkg::VALUE_W-1:0]  out_value,
  output logic        [dws_pkg::STATUS_W-1:0] out_status,
  output logic        [dws_pkg::OCC_W-1:0]    out_occupancy,
  output logic                                out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic [dws_pkg::VALUE_W-1:0] key_r;

  logic                         out_valid_r;
  logic [dws_pkg::VALUE_W-1:0]  out_value_r;
  logic [dws_pkg::STATUS_W-1:0] out_status_r;
  logic [dws_pkg::OCC_W-1:0]    out_occ_r;
  logic                         out_last_r;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [dws_pkg::VALUE_W-1:0]  ram_rdata;

  logic [AW-1:0] front_dec, front_inc, scan_ptr_inc, back_slot, tail_slot;
  logic [dws_pkg::VALUE_W-1:0] emit_value;

  // Ring index of the entry at the given offset from the front.
  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                              input logic [CW-1:0] offset);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(offset);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign front_dec    = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc    = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign scan_ptr_inc = (scan_ptr_r == AW'(DEPTH - 1)) ? '0 : scan_ptr_r + AW'(1);
  assign back_slot    = ring_slot(front_r, count_r);
  assign tail_slot    = ring_slot(front_r, count_r - CW'(1));

  always_comb begin
    front_nxt    = front_r;
    count_nxt    = count_r;
    scan_ptr_nxt = scan_ptr_r;
    scan_idx_nxt = scan_idx_r;
    ram_we       = 1'b0;
    ram_waddr    = back_slot;
    ram_re       = 1'b0;
    ram_raddr    = front_r;
    priority if (cmd.push_front) begin
      ram_we    = 1'b1;
      ram_waddr = front_dec;
      front_nxt = front_dec;
      count_nxt = count_r + CW'(1);
    end else if (cmd.push_back) begin
      ram_we    = 1'b1;
      ram_waddr = back_slot;
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_front) begin
      ram_re    = 1'b1;
      ram_raddr = front_r;
      front_nxt = front_inc;
      count_nxt = count_r - CW'(1);
    end else if (cmd.pop_back) begin
      ram_re    = 1'b1;
      ram_raddr = tail_slot;
      count_nxt = count_r - CW'(1);
    end else if (cmd.scan_start) begin
      ram_re       = 1'b1;
      ram_raddr    = front_r;
      scan_ptr_nxt = front_r;
      scan_idx_nxt = '0;
    end else if (cmd.scan_next) begin
      ram_re       = 1'b1;
      ram_raddr    = scan_ptr_inc;
      scan_ptr_nxt = scan_ptr_inc;
      scan_idx_nxt = scan_idx_r + CW'(1);
    end else begin
      ram_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr_r <= scan_ptr_nxt;
    scan_idx_r <= scan_idx_nxt;
    if (cmd.capture) begin
      key_r <= in_value;
    end
  end

  dws_ram #(
    .WIDTH (dws_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (cmd.emit_sel)
      dws_pkg::VSEL_RDATA: emit_value = ram_rdata;
      dws_pkg::VSEL_KEY:   emit_value = key_r;
      default:             emit_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r  <= emit_value;
      out_status_r <= cmd.emit_status;
      out_occ_r    <= dws_pkg::OCC_W'(count_r);
      out_last_r   <= cmd.emit_last;
    end
  end

  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.empty     = (count_r == '0);
  assign stat.match     = (ram_rdata == key_r);
  assign stat.scan_last = (scan_idx_r == count_r - CW'(1));
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;
  assign out_last      = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_front || cmd.push_back) |-> !stat.full)
    else $error("push into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_front || cmd.pop_back) |-> !stat.empty)
    else $error("pop from an empty queue");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_next |-> (scan_idx_r + CW'(1) < count_r))
    else $error("scan stepped past the back entry");

endmodule

>>> rtl/core/deque_with_search.sv
// Double-ended queue of signed 32-bit values with search and list operations.
// Top level: joins the controller and the datapath to the two channel interfaces.
// Depends on dws_pkg, dws_in_if, dws_out_if, dws_ctrl, dws_dpath and dws_ram.
//
// The queue holds up to DEPTH signed 32-bit entries in a ring held in a RAM with
// a single read port and registered read data. Each input transfer carries an
// opcode and a value: push front, push back, pop front, pop back, search for the
// value, or list every entry from front to back. Every result reports a status
// (ok or found, full, empty, not found), a value (the popped entry, the matched
// value or the listed entry, zero otherwise), the occupancy after the operation
// in five bits, and a mark on the final result of the item. A list gives one
// result per entry held; every other valid opcode gives exactly one result; the
// two unused opcodes are accepted and dropped with no result and no change. The
// input channel is ready only while the controller is idle, but a result sitting
// unclaimed in the output register does not keep the next item out. A push, a
// pop or any error case is accepted in the idle state and loads its result from
// the reply or pop state once the output register is free; a search examines
// one entry after another, up to the occupancy, since the single RAM read port
// delivers one entry per cycle; a list loads one result per entry held, and
// waits for the sink whenever the output register is still full. The entry
// RAM needs no clearing after reset: only occupied entries are ever read.
module deque_with_search #(
  // Number of entries the ring can hold, from 2 to 31 (five-bit occupancy field).
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dws_in_if.sink    in_chan,
  dws_out_if.source out_chan
);

  dws_pkg::dws_cmd_t  cmd;
  dws_pkg::dws_stat_t stat;

  // The controller decides what each transfer does; it never touches the data.
  dws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_ready  (in_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath owns the ring pointers, the count, the entry RAM and the output
  // register, which is what decouples the result channel from the input side.
  dws_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_value      (in_chan.value_in),
    .out_ready     (out_chan.ready),
    .out_valid     (out_chan.valid),
    .out_value     (out_chan.value_out),
    .out_status    (out_chan.status),
    .out_occupancy (out_chan.occupancy),
    .out_last      (out_chan.last_of_run)
  );

endmodule
